>>> hw/rtl/gwnm_pkg.sv
// gwnm_pkg: shared types, character codes and helpers for the wildcard name matcher.
// Used by gwnm_step and greedy_wildcard_name_matcher_top. No dependencies.

package gwnm_pkg;

    localparam int MASK_MAX_DEF = 32;
    localparam int POS_W        = 6;   // holds a mask position up to 32
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_LEN = 3'd4;

    typedef enum logic [1:0] {
        V_OPEN   = 2'd0,
        V_ACCEPT = 2'd1,
        V_REJECT = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             seek;
        verdict_t         verdict;
        logic             done;
    } step_res_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gwnm_step.sv
// gwnm_step: one iteration of the greedy mask scan for one name character.
// Depends on gwnm_pkg.

module gwnm_step (
    input  logic [gwnm_pkg::POS_W-1:0] pos,
    input  logic                       seek,
    input  logic [gwnm_pkg::POS_W-1:0] len,
    input  logic [7:0]                 uc,
    input  logic [7:0]                 mchar,
    output gwnm_pkg::step_res_t        res
);

    logic                       pos_ge;
    logic [gwnm_pkg::POS_W-1:0] pos_inc;
    logic [7:0]                 mfold;

    assign pos_ge  = (pos >= len);
    assign pos_inc = pos + gwnm_pkg::POS_W'(1);
    assign mfold   = gwnm_pkg::fold_case(mchar);

    always_comb
    begin
        res.pos     = pos;
        res.seek    = seek;
        res.verdict = gwnm_pkg::V_OPEN;
        res.done    = 1'b1;
        if (seek && !pos_ge && (uc != mfold))
        begin
            // still skipping
            res.seek = 1'b1;
        end
        else
        begin
            res.seek = 1'b0;
            if (pos_ge)
            begin
                res.verdict = gwnm_pkg::V_REJECT;
            end
            else if (mchar == gwnm_pkg::CHAR_STAR)
            begin
                res.pos = pos_inc;
                if (pos_inc >= len)
                begin
                    res.verdict = gwnm_pkg::V_ACCEPT;
                end
                else
                begin
                    res.seek = 1'b1;
                    res.done = 1'b0;
                end
            end
            else if (mchar == gwnm_pkg::CHAR_QMARK)
            begin
                res.pos = pos_inc;
            end
            else if (mfold != uc)
            begin
                res.verdict = gwnm_pkg::V_REJECT;
            end
            else
            begin
                res.pos = pos_inc;
            end
        end
    end

endmodule

>>> hw/rtl/greedy_wildcard_name_matcher_top.sv
// greedy_wildcard_name_matcher_top: case-insensitive greedy wildcard match of a file name.
// Depends on gwnm_pkg and gwnm_step.
//
// Usage:
//   Configure the mask through the cfg channel (index 0..3: mask bytes, low byte
//   first; index 4: mask length). cfg_ready is always high; write only while idle.
//   Stream a name one byte per input transaction (name_char, last_char). Only the
//   transaction with last_char set produces an output transaction carrying matched.
//   Timing: an input transaction while the verdict is open is accepted, then the
//   sequencer steps through the mask, one mask character per step through the shared
//   compare unit, until the byte is consumed; a name byte after the verdict is decided
//   is accepted with no step. The final byte then passes through the result state,
//   which registers matched and raises out_valid once the output register is free.
//   The effective mask length is registered, computed from the registered mask.
//   in_stall is high whenever the sequencer is not idle. The result sits in an
//   output register; the next name can stream in while it waits. If a new result
//   is ready while the previous is still stalled, the sequencer holds until
//   out_stall drops.
//   Reset clears the mask (empty mask, every name rejected) and the name state.

module greedy_wildcard_name_matcher_top #(
    parameter int MASK_MAX = gwnm_pkg::MASK_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      name_char,
    input  logic                            last_char,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            matched,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gwnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gwnm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MASK_MAX);
    localparam int POS_W = gwnm_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          mask_reg [MASK_MAX];
    logic [POS_W-1:0]    mask_len_reg;
    logic [POS_W-1:0]    eff_len_reg, eff_len_next;
    logic [POS_W-1:0]    pos_reg;
    logic                seek_reg;
    gwnm_pkg::verdict_t  verdict_reg;
    logic [1:0]          seen_reg;
    logic                dots_reg;
    logic [7:0]          uc_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic                matched_reg;

    logic                in_fire;
    logic                out_free;
    logic                sds;
    logic                result;
    logic [POS_W-1:0]    clamp_len;
    logic [7:0]          mchar;
    gwnm_pkg::step_res_t step;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // mask registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MASK_MAX; b++)
            begin
                mask_reg[b] <= 8'h00;
            end
            mask_len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            for (int b = 0; b < MASK_MAX; b++)
            begin
                if (cfg_index == gwnm_pkg::CFG_IDX_W'(b / 8))
                begin
                    mask_reg[b] <= cfg_data[(b % 8) * 8 +: 8];
                end
            end
            if (cfg_index == gwnm_pkg::REG_MASK_LEN)
            begin
                mask_len_reg <= cfg_data[POS_W-1:0];
            end
        end
    end

    // effective length: clamp, then cut at first zero byte
    assign clamp_len = (mask_len_reg > POS_W'(MASK_MAX)) ? POS_W'(MASK_MAX) : mask_len_reg;

    always_comb
    begin
        eff_len_next = clamp_len;
        for (int i = MASK_MAX - 1; i >= 0; i--)
        begin
            if ((mask_reg[i] == 8'h00) && (POS_W'(i) < clamp_len))
            begin
                eff_len_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= '0;
        end
        else
        begin
            eff_len_reg <= eff_len_next;
        end
    end

    assign mchar = mask_reg[pos_reg[IDX_W-1:0]];

    gwnm_step u_step (
        .pos   (pos_reg),
        .seek  (seek_reg),
        .len   (eff_len_reg),
        .uc    (uc_reg),
        .mchar (mchar),
        .res   (step)
    );

    assign sds = (eff_len_reg == POS_W'(3)) &&
                 (mask_reg[0] == gwnm_pkg::CHAR_STAR) &&
                 (mask_reg[1] == gwnm_pkg::CHAR_DOT) &&
                 (mask_reg[2] == gwnm_pkg::CHAR_STAR);

    always_comb
    begin
        if (dots_reg && (seen_reg <= 2'd2))
            result = 1'b0;
        else if (sds)
            result = 1'b1;
        else if (verdict_reg == gwnm_pkg::V_ACCEPT)
            result = 1'b1;
        else if (verdict_reg == gwnm_pkg::V_REJECT)
            result = 1'b0;
        else if (seek_reg)
            result = 1'b0;
        else
            result = (pos_reg >= eff_len_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (verdict_reg == gwnm_pkg::V_OPEN)
                        state_next = ST_STEP;
                    else if (last_char)
                        state_next = ST_FIN;
                end
            end
            ST_STEP:
            begin
                if (step.done)
                    state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer and name state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            seek_reg      <= 1'b0;
            verdict_reg   <= gwnm_pkg::V_OPEN;
            seen_reg      <= 2'd0;
            dots_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if (seen_reg != 2'd3)
                    seen_reg <= seen_reg + 2'd1;
                if (name_char != gwnm_pkg::CHAR_DOT)
                    dots_reg <= 1'b0;
            end
            if (state_reg == ST_STEP)
            begin
                pos_reg     <= step.pos;
                seek_reg    <= step.seek;
                verdict_reg <= step.verdict;
            end
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= '0;
                seek_reg      <= 1'b0;
                verdict_reg   <= gwnm_pkg::V_OPEN;
                seen_reg      <= 2'd0;
                dots_reg      <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            uc_reg   <= gwnm_pkg::fold_case(name_char);
            last_reg <= last_char;
        end
        if ((state_reg == ST_FIN) && out_free)
            matched_reg <= result;
    end

    a_no_result_mid_name: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !last_char && !out_valid) |=> !out_valid)
        else $error("result produced for a non-final character");

    a_step_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && step.done && last_reg) |=> (state_reg == ST_FIN))
        else $error("final character did not reach result stage");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FIN))
        else $error("output transaction raised outside result stage");

endmodule

>>> sim/greedy_wildcard_name_matcher_top_tb.sv
// Self-checking testbench for greedy_wildcard_name_matcher_top: streams file names against
// a series of wildcard masks and checks every verdict against an in-bench predictor.
// Depends on gwnm_pkg and the matcher RTL only.

module greedy_wildcard_name_matcher_top_tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_WAIT       = 16;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 550;

    localparam logic [gwnm_pkg::CFG_IDX_W-1:0] REG_MASK_W0 = 3'd0;
    localparam logic [gwnm_pkg::CFG_IDX_W-1:0] REG_MASK_W3 = 3'd3;

    typedef logic [7:0] char_q_t[$];

    class match_scoreboard;
        logic [63:0]        mask_word [4];
        logic [5:0]         mask_len;
        int unsigned        mask_pos;
        bit                 seeking;
        gwnm_pkg::verdict_t verdict;
        int unsigned        seen;
        bit                 dots_only;
        bit                 verdicts_due [$];
        int                 errors;
        int                 names_checked;
        int                 names_matched;

        function new();
            for (int i = 0; i < 4; i++)
            begin
                mask_word[i] = 64'd0;
            end
            mask_len      = 6'd0;
            errors        = 0;
            names_checked = 0;
            names_matched = 0;
            clear_name();
        endfunction

        function void clear_name();
            mask_pos  = 0;
            seeking   = 1'b0;
            verdict   = gwnm_pkg::V_OPEN;
            seen      = 0;
            dots_only = 1'b1;
        endfunction

        function void apply_reg(logic [gwnm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == gwnm_pkg::REG_MASK_LEN)
            begin
                mask_len = data[5:0];
            end
            else if (idx <= REG_MASK_W3)
            begin
                mask_word[idx[1:0]] = data;
            end
        endfunction

        function logic [7:0] mask_char(int unsigned i);
            return mask_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
        endfunction

        function logic [7:0] upcase(logic [7:0] c);
            return (c >= gwnm_pkg::CHAR_LC_A && c <= gwnm_pkg::CHAR_LC_Z) ?
                   c - gwnm_pkg::CASE_DIFF : c;
        endfunction

        function int unsigned active_len();
            int unsigned n;
            n = mask_len;
            if (n > gwnm_pkg::MASK_MAX_DEF)
            begin
                n = gwnm_pkg::MASK_MAX_DEF;
            end
            for (int unsigned i = 0; i < n; i++)
            begin
                if (mask_char(i) == 8'h00)
                begin
                    return i;
                end
            end
            return n;
        endfunction

        // greedy scan, no backtracking; a star may chain into the next mask char
        function void advance(logic [7:0] c, int unsigned len);
            logic [7:0] uc;
            logic [7:0] m;
            uc = upcase(c);
            for (int guard = 0; guard <= gwnm_pkg::MASK_MAX_DEF + 2; guard++)
            begin
                if (seeking)
                begin
                    if (mask_pos < len && uc != upcase(mask_char(mask_pos)))
                    begin
                        return;
                    end
                    seeking = 1'b0;
                end
                if (mask_pos >= len)
                begin
                    verdict = gwnm_pkg::V_REJECT;
                    return;
                end
                m = mask_char(mask_pos);
                if (m == gwnm_pkg::CHAR_STAR)
                begin
                    mask_pos++;
                    if (mask_pos >= len)
                    begin
                        verdict = gwnm_pkg::V_ACCEPT;
                        return;
                    end
                    seeking = 1'b1;
                end
                else if (m == gwnm_pkg::CHAR_QMARK)
                begin
                    mask_pos++;
                    return;
                end
                else
                begin
                    if (upcase(m) != uc)
                    begin
                        verdict = gwnm_pkg::V_REJECT;
                        return;
                    end
                    mask_pos++;
                    return;
                end
            end
        endfunction

        function void note_input(logic [7:0] c, logic last);
            int unsigned len;
            bit          v;
            len = active_len();
            if (seen < 3)
            begin
                seen++;
            end
            if (c != gwnm_pkg::CHAR_DOT)
            begin
                dots_only = 1'b0;
            end
            if (verdict == gwnm_pkg::V_OPEN)
            begin
                advance(c, len);
            end
            if (last)
            begin
                if (dots_only && seen <= 2)
                    v = 1'b0;
                else if (len == 3 && mask_char(0) == gwnm_pkg::CHAR_STAR &&
                         mask_char(1) == gwnm_pkg::CHAR_DOT &&
                         mask_char(2) == gwnm_pkg::CHAR_STAR)
                    v = 1'b1;
                else if (verdict == gwnm_pkg::V_ACCEPT)
                    v = 1'b1;
                else if (verdict == gwnm_pkg::V_REJECT)
                    v = 1'b0;
                else if (seeking)
                    v = 1'b0;
                else
                    v = (mask_pos >= len);
                verdicts_due.push_back(v);
                clear_name();
            end
        endfunction

        function void check_result(logic m);
            bit want;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result, matched=%0b", $time, m);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                names_checked++;
                if (m === 1'b1)
                begin
                    names_matched++;
                end
                if (m !== want)
                begin
                    $display("%0t: matched mismatch, expected %0b, actual %0b", $time, want, m);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [7:0]                      name_char = 8'd0;
    logic                            last_char = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            matched;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gwnm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gwnm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    match_scoreboard sb = new();
    int idle_cycles   = 0;
    int items_sent    = 0;
    int mask_settings = 0;
    bit no_idle       = 1'b0;

    greedy_wildcard_name_matcher_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .name_char (name_char),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .matched   (matched),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                sb.note_input(name_char, last_char);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(matched);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.apply_reg(cfg_index, cfg_data);
            end
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("greedy_wildcard_name_matcher_top_tb failed");
        $finish;
    end

    function automatic int draw_wait();
        if (no_idle)
        begin
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (hold - 1) @(negedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        name_char = c;
        last_char = last;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_name(char_q_t s);
        foreach (s[i])
        begin
            send_char(s[i], i == s.size() - 1);
        end
    endtask

    // wait for all verdicts, then for a trailing byte still in the step unit
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [gwnm_pkg::CFG_IDX_W-1:0] idx,
                             logic [gwnm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_mask(char_q_t chars, int len, bit fill_random);
        logic [63:0] word;
        logic [63:0] len_data;
        for (int w = 0; w < 4; w++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                if (w * 8 + b < chars.size())
                    word[b * 8 +: 8] = chars[w * 8 + b];
                else
                    word[b * 8 +: 8] = fill_random ? 8'($urandom_range(0, 255)) : 8'h00;
            end
            cfg_write(REG_MASK_W0 + 3'(w), word);
        end
        len_data = {$urandom(), $urandom()};
        len_data = fill_random ? {len_data[63:6], 6'(len)} : 64'(6'(len));
        cfg_write(gwnm_pkg::REG_MASK_LEN, len_data);
        mask_settings++;
    endtask

    function automatic char_q_t chars_of(string s);
        char_q_t q;
        foreach (s[i])
        begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        logic [7:0] lc;
        lc = c | gwnm_pkg::CASE_DIFF;
        if (lc >= gwnm_pkg::CHAR_LC_A && lc <= gwnm_pkg::CHAR_LC_Z &&
            $urandom_range(0, 1) == 1)
        begin
            return c ^ gwnm_pkg::CASE_DIFF;
        end
        return c;
    endfunction

    function automatic logic [7:0] filler_char();
        case ($urandom_range(0, 9))
            0:       return gwnm_pkg::CHAR_DOT;
            1:       return ($urandom_range(0, 1) == 1) ? gwnm_pkg::CHAR_STAR
                                                        : gwnm_pkg::CHAR_QMARK;
            default: return flip_case(gwnm_pkg::CHAR_LC_A + 8'($urandom_range(0, 3)));
        endcase
    endfunction

    function automatic char_q_t random_mask();
        char_q_t q;
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            return chars_of("*.*");
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, gwnm_pkg::MASK_MAX_DEF)
                                        : $urandom_range(1, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1:    q.push_back(gwnm_pkg::CHAR_STAR);
                2:       q.push_back(gwnm_pkg::CHAR_QMARK);
                3:       q.push_back(gwnm_pkg::CHAR_DOT);
                default: q.push_back(flip_case(gwnm_pkg::CHAR_LC_A +
                                               8'($urandom_range(0, 3))));
            endcase
        end
        return q;
    endfunction

    // mostly names built to fit the mask, some mutated, some dot-only, the rest noise
    function automatic char_q_t random_name(char_q_t mask);
        char_q_t q;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            foreach (mask[i])
            begin
                if (mask[i] == gwnm_pkg::CHAR_STAR)
                    repeat ($urandom_range(0, 3)) q.push_back(filler_char());
                else if (mask[i] == gwnm_pkg::CHAR_QMARK)
                    q.push_back(($urandom_range(0, 1) == 1) ? filler_char()
                                                             : 8'($urandom_range(1, 255)));
                else
                    q.push_back(flip_case(mask[i]));
            end
            if (q.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       void'(q.pop_back());
                    1:       q.push_back(filler_char());
                    default: q[$urandom_range(0, q.size() - 1)] = filler_char();
                endcase
            end
        end
        else if (kind == 7)
        begin
            q = ($urandom_range(0, 1) == 1) ? chars_of(".") : chars_of("..");
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                q.push_back(($urandom_range(0, 1) == 1) ? filler_char()
                                                         : 8'($urandom_range(1, 255)));
            end
        end
        if (q.size() == 0)
        begin
            q.push_back(filler_char());
        end
        return q;
    endfunction

    task automatic run_phase();
        char_q_t mask;
        int len;
        drain();
        no_idle = ($urandom_range(0, 3) == 0);
        mask = random_mask();
        len = mask.size();
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(0, 63);
            1:       len = gwnm_pkg::MASK_MAX_DEF;
            default: ;
        endcase
        load_mask(mask, len, $urandom_range(0, 1));
        repeat ($urandom_range(4, 12))
        begin
            send_name(random_name(mask));
        end
    endtask

    initial
    begin : stimulus
        char_q_t q;
        int random_start;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty mask after reset
        send_name(chars_of("a"));
        drain();
        load_mask(chars_of("*.*"), 3, 1'b0);
        send_name(chars_of("."));
        send_name(chars_of(".."));
        send_name(chars_of("..."));
        send_name(chars_of("x"));
        drain();
        // case folding, '?' on a zero byte, trailing star
        load_mask(chars_of("A?c*"), 4, 1'b0);
        q = '{8'h61, 8'h00, 8'h43, 8'h51};
        send_name(q);
        drain();
        load_mask(chars_of("**x"), 3, 1'b0);
        send_name(chars_of("*x"));
        drain();
        // all-ones mask words, length clipped to the maximum
        q.delete();
        repeat (gwnm_pkg::MASK_MAX_DEF) q.push_back(8'hFF);
        load_mask(q, 63, 1'b0);
        q = '{8'hFF, 8'hFF};
        send_name(q);
        drain();
        q = '{8'h61, 8'h62, 8'h00, 8'h63, 8'h64};
        load_mask(q, 5, 1'b0);
        send_name(chars_of("AB"));
        drain();
        load_mask(chars_of("*z"), 2, 1'b0);
        send_name(chars_of("ab"));
        drain();
        load_mask(chars_of("ab"), 2, 1'b0);
        send_name(chars_of("abc"));
        // mask changed in mid-name
        send_char(gwnm_pkg::CHAR_LC_A, 1'b0);
        drain();
        load_mask(chars_of("x*"), 2, 1'b0);
        send_char(gwnm_pkg::CHAR_LC_A + 8'd16, 1'b1);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            run_phase();
        end
        no_idle = 1'b0;
        drain();

        $display("Drove %0d name characters over %0d mask settings;",
                 items_sent, mask_settings);
        $display("%0d verdicts checked, %0d matches.", sb.names_checked, sb.names_matched);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("greedy_wildcard_name_matcher_top_tb passed");
        else
            $display("greedy_wildcard_name_matcher_top_tb failed");
        $finish;
    end

endmodule
